/* rtl/hsc_pkg.sv */
// hsc_pkg: band codes and color ramp tables for the hillshade colorizer.
// No dependencies.
package hsc_pkg;

	typedef logic [1:0] band_t;

	localparam band_t BAND_WATER = 2'd0;
	localparam band_t BAND_GRASS = 2'd1;
	localparam band_t BAND_ROCK  = 2'd2;
	localparam band_t BAND_SNOW  = 2'd3;

	localparam int NUM_CH = 3;

	typedef logic [7:0] ramp_row_t [NUM_CH];

	// per band: red, green, blue
	localparam ramp_row_t RAMP_BASE [4] = '{
		'{8'd10, 8'd60, 8'd140},
		'{8'd30, 8'd100, 8'd30},
		'{8'd80, 8'd85, 8'd70},
		'{8'd200, 8'd200, 8'd200}
	};

	localparam ramp_row_t RAMP_SPAN [4] = '{
		'{8'd40, 8'd70, 8'd100},
		'{8'd50, 8'd110, 8'd40},
		'{8'd60, 8'd55, 8'd50},
		'{8'd55, 8'd55, 8'd55}
	};

	// floor(v / 6) = (v * RECIP6) >> RECIP6_SHIFT for v below 2048
	localparam int RECIP6       = 683;
	localparam int RECIP6_SHIFT = 12;

endpackage

/* rtl/hsc_height_if.sv */
// hsc_height_if: request channel carrying one pixel neighborhood of heights.
// Depends on nothing.
interface hsc_height_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] center_height;
	logic signed [15:0] left_height;
	logic signed [15:0] right_height;
	logic signed [15:0] up_height;
	logic signed [15:0] down_height;

	modport source(output valid, center_height, left_height, right_height, up_height,
		down_height, input ready);
	modport sink(input valid, center_height, left_height, right_height, up_height,
		down_height, output ready);
endinterface

/* rtl/hsc_pixel_if.sv */
// hsc_pixel_if: request channel carrying one shaded RGB pixel.
// Depends on nothing.
interface hsc_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

/* rtl/hsc_isqdiv.sv */
// hsc_isqdiv: pipelined floor(sqrt(floor(p2 * 2^(2S) / d))), saturated to S bits.
// Restoring divider (one quotient bit per stage) then digit-by-digit root.
// No package dependencies.
module hsc_isqdiv #(
	parameter int S      = 16,
	parameter int DW     = 39,
	parameter int P2W    = 39,
	parameter int SIDE_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [P2W-1:0]    p2,
	input  logic [DW-1:0]     d,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [S-1:0]      dq,
	output logic [SIDE_W-1:0] side_out
);

	localparam int QW   = 2 * S + 1;
	localparam int NDIV = QW;
	localparam int NSQ  = S + 1;
	localparam int NST  = NDIV + NSQ;
	localparam int RW   = S + 3;
	localparam int XW   = 2 * NSQ;

	logic              v_s   [NST];
	logic [SIDE_W-1:0] sd_s  [NST];

	logic [DW-1:0] rem_s [NDIV];
	logic [DW-1:0] dv_s  [NDIV];
	logic [QW-1:0] quo_s [NDIV];

	logic [S:0]    root_s [NSQ];
	logic [RW-1:0] srem_s [NSQ];
	logic [XW-1:0] x_s    [NSQ];

	genvar i;
	generate
		for (i = 0; i < NST; i++) begin : g_ctl
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (adv) begin
					v_s[i] <= (i == 0) ? in_valid : v_s[(i == 0) ? 0 : i - 1];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sd_s[i] <= (i == 0) ? side_in : sd_s[(i == 0) ? 0 : i - 1];
				end
			end
		end

		for (i = 0; i < NDIV; i++) begin : g_div
			logic [DW-1:0] r_prev;
			logic [DW-1:0] d_prev;
			logic [QW-1:0] q_prev;
			logic          b_in;
			logic [DW:0]   t;
			logic          ge;
			logic [DW:0]   diff;

			if (i == 0) begin : g_first
				// remainder starts at p2 >> 1; the quotient is known to fit QW bits
				assign r_prev = DW'(p2 >> 1);
				assign d_prev = d;
				assign q_prev = '0;
				assign b_in   = p2[0];
			end else begin : g_next
				assign r_prev = rem_s[i-1];
				assign d_prev = dv_s[i-1];
				assign q_prev = quo_s[i-1];
				assign b_in   = 1'b0;
			end

			always_comb begin
				t    = {r_prev, b_in};
				ge   = (t >= {1'b0, d_prev});
				diff = t - {1'b0, d_prev};
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
					dv_s[i]  <= d_prev;
					quo_s[i] <= {q_prev[QW-2:0], ge};
				end
			end
		end

		for (i = 0; i < NSQ; i++) begin : g_sqrt
			logic [S:0]    rt_prev;
			logic [RW-1:0] sr_prev;
			logic [XW-1:0] x_prev;
			logic [RW+1:0] t;
			logic [RW+1:0] trial;
			logic          ge;
			logic [RW+1:0] diff;

			if (i == 0) begin : g_first
				assign rt_prev = '0;
				assign sr_prev = '0;
				assign x_prev  = XW'(quo_s[NDIV-1]);
			end else begin : g_next
				assign rt_prev = root_s[i-1];
				assign sr_prev = srem_s[i-1];
				assign x_prev  = x_s[i-1];
			end

			always_comb begin
				t     = {sr_prev, x_prev[XW-1 -: 2]};
				trial = (RW + 2)'({rt_prev, 2'b01});
				ge    = (t >= trial);
				diff  = t - trial;
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					srem_s[i] <= ge ? diff[RW-1:0] : t[RW-1:0];
					root_s[i] <= {rt_prev[S-1:0], ge};
					x_s[i]    <= {x_prev[XW-3:0], 2'b00};
				end
			end
		end
	endgenerate

	// a full-scale root of 2^S saturates to the largest code
	assign dq        = root_s[NSQ-1][S] ? {S{1'b1}} : root_s[NSQ-1][S-1:0];
	assign out_valid = v_s[NST-1];
	assign side_out  = sd_s[NST-1];

endmodule

/* rtl/terrain_hillshade_color_top.sv */
// terrain_hillshade_color_top: Lambert hillshade with four-band color ramp.
// One pixel per clock while the output register is empty or being taken.
// Depth comes from the divider (2S+1 stages) and square root (S+1 stages).
// Whole pipeline advances together; it holds while the output is full and not taken.
// arst_n clears all valid bits; data registers are not reset.
module terrain_hillshade_color_top #(
	parameter int HEIGHT_FRAC_BITS = 14,
	parameter int SHADE_FRAC_BITS  = 16
) (
	input logic         clk,
	input logic         arst_n,
	hsc_height_if.sink  heights,
	hsc_pixel_if.source pixel
);

	localparam int F    = (HEIGHT_FRAC_BITS > 16) ? 16 : HEIGHT_FRAC_BITS;
	localparam int DROP = HEIGHT_FRAC_BITS - F;
	localparam int CW   = (HEIGHT_FRAC_BITS + 2 > 17) ? HEIGHT_FRAC_BITS + 2 : 17;
	localparam int S    = SHADE_FRAC_BITS;
	localparam int DW   = 2 * F + 7;
	localparam int P2W  = 2 * F + 7;
	localparam int PRW  = F + 10;
	localparam int SIDE_W = 8 * hsc_pkg::NUM_CH;

	localparam logic signed [CW-1:0] ONE_IN = {{(CW-1){1'b0}}, 1'b1} << HEIGHT_FRAC_BITS;
	localparam logic [F+2:0] ONE_F = {{(F+2){1'b0}}, 1'b1} << F;
	localparam logic [F+5:0] ONE_W = {{(F+5){1'b0}}, 1'b1} << F;
	localparam logic [F+5:0] SIX_ONE_W = (ONE_W << 2) + (ONE_W << 1);
	localparam logic [F+5:0] THREE_ONE_W = (ONE_W << 1) + ONE_W;
	localparam logic signed [F+4:0] FOUR_ONE = {{(F+4){1'b0}}, 1'b1} << (F + 2);
	localparam logic [DW-1:0] FOUR_ONE_SQ = {{(DW-1){1'b0}}, 1'b1} << (2 * F + 2);

	logic adv;
	logic out_valid_q;

	// ---------------- stage 1: clamp, reduce, slopes
	logic signed [15:0]   hraw [5];
	logic signed [CW-1:0] hx   [5];
	logic signed [CW-1:0] hcl  [5];
	logic [CW-1:0]        hoff [5];
	logic [F+2:0]         hred [5];
	logic signed [F+2:0]  hs   [5];

	assign hraw[0] = heights.center_height;
	assign hraw[1] = heights.left_height;
	assign hraw[2] = heights.right_height;
	assign hraw[3] = heights.up_height;
	assign hraw[4] = heights.down_height;

	genvar j;
	generate
		for (j = 0; j < 5; j++) begin : g_take
			always_comb begin
				hx[j] = {{(CW-16){hraw[j][15]}}, hraw[j]};
				if (hx[j] > ONE_IN)
					hcl[j] = ONE_IN;
				else if (hx[j] < -ONE_IN)
					hcl[j] = -ONE_IN;
				else
					hcl[j] = hx[j];
				hoff[j] = unsigned'(hcl[j] + ONE_IN);
				hred[j] = (F + 3)'(hoff[j] >> DROP);
				hs[j]   = signed'(hred[j] - ONE_F);
			end
		end
	endgenerate

	logic                v_s1;
	logic signed [F+2:0] a_s1;
	logic signed [F+2:0] b_s1;
	logic [F+1:0]        u_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= heights.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= hs[2] - hs[1];
			b_s1 <= hs[4] - hs[3];
			u_s1 <= hred[0][F+1:0];
		end
	end

	// ---------------- stage 2: numerator, squares, band select
	logic signed [F+4:0]  p_w;
	logic signed [2*F+5:0] asq_w;
	logic signed [2*F+5:0] bsq_w;
	logic [F+5:0]         u_w;
	logic [F+5:0]         u10_w;
	hsc_pkg::band_t       band_w;
	logic [F+5:0]         num_w;

	always_comb begin
		p_w   = FOUR_ONE - {{2{a_s1[F+2]}}, a_s1} - {{2{b_s1[F+2]}}, b_s1};
		asq_w = a_s1 * a_s1;
		bsq_w = b_s1 * b_s1;
		u_w   = (F + 6)'(u_s1);
		u10_w = (u_w << 3) + (u_w << 1);
		if (u10_w < SIX_ONE_W) begin
			band_w = hsc_pkg::BAND_WATER;
			num_w  = u10_w;
		end else if (u_w < ONE_W) begin
			band_w = hsc_pkg::BAND_GRASS;
			num_w  = u10_w - SIX_ONE_W;
		end else if ((u_w << 1) < THREE_ONE_W) begin
			band_w = hsc_pkg::BAND_ROCK;
			num_w  = (u_w - ONE_W) << 1;
		end else begin
			band_w = hsc_pkg::BAND_SNOW;
			num_w  = (u_w << 1) - THREE_ONE_W;
		end
	end

	logic                 v_s2;
	logic [F+3:0]         p_s2;
	logic [2*F+2:0]       asq_s2;
	logic [2*F+2:0]       bsq_s2;
	hsc_pkg::band_t       band_s2;
	logic [F+2:0]         num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2    <= p_w[F+3:0];
			asq_s2  <= asq_w[2*F+2:0];
			bsq_s2  <= bsq_w[2*F+2:0];
			band_s2 <= band_w;
			num_s2  <= num_w[F+2:0];
		end
	end

	// ---------------- stage 3: p^2, 6q, ramp products
	logic [DW-1:0]  q_w;
	logic [2*F+7:0] p2_w;

	always_comb begin
		q_w  = DW'(asq_s2) + DW'(bsq_s2) + FOUR_ONE_SQ;
		p2_w = (2 * F + 8)'(p_s2) * (2 * F + 8)'(p_s2);
	end

	logic           v_s3;
	logic [P2W-1:0] p2_s3;
	logic [DW-1:0]  q6_s3;
	hsc_pkg::band_t band_s3;
	logic [PRW-1:0] prod_s3 [hsc_pkg::NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s3   <= p2_w[P2W-1:0];
			q6_s3   <= (q_w << 2) + (q_w << 1);
			band_s3 <= band_s2;
		end
	end

	logic [7:0] chan_w [hsc_pkg::NUM_CH];
	logic [SIDE_W-1:0] side_w;

	genvar c;
	generate
		for (c = 0; c < hsc_pkg::NUM_CH; c++) begin : g_ch
			logic [9:0]  w0;
			logic [21:0] w0m;
			logic [PRW-1:0] frac;

			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s3[c] <= PRW'(num_s2) * PRW'(hsc_pkg::RAMP_SPAN[band_s2][c]);
				end
			end

			always_comb begin
				w0  = 10'(prod_s3[c] >> F);
				w0m = 22'(w0) * 22'(hsc_pkg::RECIP6);
				case (band_s3)
					hsc_pkg::BAND_WATER: frac = PRW'(w0m >> hsc_pkg::RECIP6_SHIFT);
					hsc_pkg::BAND_GRASS: frac = prod_s3[c] >> (F + 2);
					default:             frac = prod_s3[c] >> F;
				endcase
				chan_w[c] = hsc_pkg::RAMP_BASE[band_s3][c] + frac[7:0];
			end

			assign side_w[8*c +: 8] = chan_w[c];
		end
	endgenerate

	// ---------------- divide and root
	logic              v_dq;
	logic [S-1:0]      dq;
	logic [SIDE_W-1:0] side_dq;

	hsc_isqdiv #(
		.S      (S),
		.DW     (DW),
		.P2W    (P2W),
		.SIDE_W (SIDE_W)
	) u_isqdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.p2        (p2_s3),
		.d         (q6_s3),
		.side_in   (side_w),
		.out_valid (v_dq),
		.dq        (dq),
		.side_out  (side_dq)
	);

	// ---------------- shade and output register
	logic [7:0]   shade_w [hsc_pkg::NUM_CH];
	logic [7:0]   pix_q   [hsc_pkg::NUM_CH];

	generate
		for (c = 0; c < hsc_pkg::NUM_CH; c++) begin : g_shade
			logic [S+7:0] m;
			always_comb begin
				m          = (S + 8)'(side_dq[8*c +: 8]) * (S + 8)'(dq);
				shade_w[c] = m[S +: 8];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					pix_q[c] <= shade_w[c];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_dq;
		end
	end

	assign adv           = !out_valid_q || pixel.ready;
	assign heights.ready = adv;
	assign pixel.valid   = out_valid_q;
	assign pixel.red     = pix_q[0];
	assign pixel.green   = pix_q[1];
	assign pixel.blue    = pix_q[2];

	// ---------------- checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> heights.ready)
		else $error("input blocked while output register empty");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_dq |=> out_valid_q)
		else $error("result from root stage did not reach output");

	a_snow_gray: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && band_s3 == hsc_pkg::BAND_SNOW |-> chan_w[0] == chan_w[1]
			&& chan_w[1] == chan_w[2])
		else $error("snow band color not gray");

endmodule

/* bench/hsc_pkg.sv */
// Bench side of the shared definitions: the package hsc_pkg is compiled from rtl/hsc_pkg.sv.
// Nothing is declared here, so the bench and the RTL share one definition.

/* bench/hsc_ifs.sv */
// Bench side of the request channels: hsc_height_if and hsc_pixel_if are compiled
// from the rtl folder. Nothing is declared here, so each interface has one definition.

/* bench/terrain_hillshade_color_top_tb.sv */
// Testbench for terrain_hillshade_color_top: drives height neighborhoods, predicts
// the shaded RGB pixel of each one and checks results in order. Needs hsc_pkg and the
// hsc_height_if / hsc_pixel_if channel interfaces.
module terrain_hillshade_color_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HFB = 14;
	localparam int SFB = 16;
	localparam int LATENCY = 3 * SFB + 6;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	int   idle_cycles = 0;
	bit   hold_sink = 1'b0;
	bit   sink_stalls = 1'b1;
	pixel_t shaded_q [$];

	hsc_height_if heights ();
	hsc_pixel_if  pixel ();

	terrain_hillshade_color_top #(.HEIGHT_FRAC_BITS(HFB), .SHADE_FRAC_BITS(SFB)) DUT (
		.clk(clk), .arst_n(arst_n), .heights(heights.sink), .pixel(pixel.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		heights.valid = 1'b0;
		heights.center_height = '0;
		heights.left_height = '0;
		heights.right_height = '0;
		heights.up_height = '0;
		heights.down_height = '0;
		pixel.ready = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// clamp to [-1,1] and bring to at most 16 fraction bits
	function automatic longint clamp_height(logic signed [15:0] raw);
		longint s, one_in;
		int drop;
		one_in = longint'(1) << HFB;
		drop = HFB > 16 ? HFB - 16 : 0;
		s = raw;
		if (s > one_in) s = one_in;
		if (s < -one_in) s = -one_in;
		return ((s + one_in) >>> drop) - (one_in >>> drop);
	endfunction

	// floor(2^S * p / sqrt(6 q)), saturated
	function automatic longint shade_factor(longint p, longint q);
		logic [127:0] rhs, lhs;
		longint lo, hi, mid;
		rhs = 128'(p * p) << (2 * SFB);
		lo = 0;
		hi = longint'(1) << SFB;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			lhs = 128'(mid * mid) * 128'(6 * q);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		if (lo > (longint'(1) << SFB) - 1) lo = (longint'(1) << SFB) - 1;
		return lo;
	endfunction

	function automatic pixel_t predict_pixel(logic signed [15:0] c, l, r, up, dn);
		longint one, hc, a, b, p, q, dq, u, num, den, chan;
		hsc_pkg::band_t band;
		logic [7:0] ch [hsc_pkg::NUM_CH];
		pixel_t px;
		one = (longint'(1) << HFB) >>> (HFB > 16 ? HFB - 16 : 0);
		hc = clamp_height(c);
		a = clamp_height(r) - clamp_height(l);
		b = clamp_height(dn) - clamp_height(up);
		p = 4 * one - a - b;
		dq = 0;
		if (p > 0) begin
			q = a * a + b * b + 4 * one * one;
			dq = shade_factor(p, q);
		end
		u = hc + one;
		if (10 * u < 6 * one) begin
			band = hsc_pkg::BAND_WATER; num = 10 * u; den = 6 * one;
		end else if (u < one) begin
			band = hsc_pkg::BAND_GRASS; num = 10 * u - 6 * one; den = 4 * one;
		end else if (2 * u < 3 * one) begin
			band = hsc_pkg::BAND_ROCK; num = 2 * (u - one); den = one;
		end else begin
			band = hsc_pkg::BAND_SNOW; num = 2 * u - 3 * one; den = one;
		end
		for (int i = 0; i < hsc_pkg::NUM_CH; i++) begin
			chan = longint'(hsc_pkg::RAMP_BASE[band][i])
				+ (longint'(hsc_pkg::RAMP_SPAN[band][i]) * num) / den;
			ch[i] = 8'((chan * dq) >> SFB);
		end
		px.red = ch[0];
		px.green = ch[1];
		px.blue = ch[2];
		return px;
	endfunction

	// valid stays up after the accepting edge; it drops only for a gap or a drain
	task automatic send_heights(logic signed [15:0] c, l, r, up, dn);
		int g;
		g = gap_len();
		if (g > 0) begin
			heights.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		heights.valid <= 1'b1;
		heights.center_height <= c;
		heights.left_height <= l;
		heights.right_height <= r;
		heights.up_height <= up;
		heights.down_height <= dn;
		do @(posedge clk); while (!heights.ready);
		shaded_q.push_back(predict_pixel(c, l, r, up, dn));
	endtask

	task automatic drain_results();
		heights.valid <= 1'b0;
		while (shaded_q.size() != 0) @(posedge clk);
	endtask

	// sink: random stalls, or a forced long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				pixel.ready <= 1'b0;
				@(posedge clk);
			end else begin
				g = sink_stalls ? gap_len() : 0;
				if (g > 0) begin
					pixel.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end else begin
					pixel.ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (pixel.valid && pixel.ready) begin
			if (shaded_q.size() == 0) begin
				$error("pixel with no request pending");
				errors++;
			end else begin
				want = shaded_q.pop_front();
				if (pixel.red !== want.red) begin
					$error("red: expected %0d got %0d", want.red, pixel.red);
					errors++;
				end
				if (pixel.green !== want.green) begin
					$error("green: expected %0d got %0d", want.green, pixel.green);
					errors++;
				end
				if (pixel.blue !== want.blue) begin
					$error("blue: expected %0d got %0d", want.blue, pixel.blue);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((heights.valid && heights.ready) || (pixel.valid && pixel.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_height();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom());
		if (r == 1) return 16'sd16384 - 16'($urandom_range(0, 3));
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// flat and extreme slopes, every band edge, out-of-range heights
	task automatic test_directed();
		logic signed [15:0] h;
		int band_edges [8];
		send_heights(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_heights(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
		send_heights(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
		send_heights(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_heights(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_heights(16'sd0, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
		send_heights(16'sd0, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
		send_heights(16'sd0, 16'sd4000, -16'sd4000, 16'sd4000, -16'sd4000);
		send_heights(16'sd0, -16'sd2000, 16'sd2000, 16'sd0, 16'sd0);
		// band edges t = 0.30, 0.50, 0.75 are h = -0.4, 0, 0.5
		band_edges = '{-6554, -6553, -1, 0, 8191, 8192, 8193, 16383};
		foreach (band_edges[i]) begin
			h = 16'(band_edges[i]);
			send_heights(h, 16'sd100, 16'sd300, 16'sd50, 16'sd200);
		end
		send_heights(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_heights(rand_height(), rand_height(), rand_height(), rand_height(),
				rand_height());
	endtask

	// output blocked long enough to fill the pipe and stall the input
	task automatic test_backpressure();
		fork
			begin
				hold_sink = 1'b1;
				repeat (8 * LATENCY) @(posedge clk);
				hold_sink = 1'b0;
			end
			test_random(2 * LATENCY);
		join
		drain_results();
	endtask

	task automatic test_streaming();
		sink_stalls = 1'b0;
		for (int i = 0; i < 150; i++) begin
			heights.valid <= 1'b1;
			heights.center_height <= rand_height();
			heights.left_height <= rand_height();
			heights.right_height <= rand_height();
			heights.up_height <= rand_height();
			heights.down_height <= rand_height();
			#1;
			do @(posedge clk); while (!heights.ready);
			shaded_q.push_back(predict_pixel(heights.center_height, heights.left_height,
				heights.right_height, heights.up_height, heights.down_height));
		end
		sink_stalls = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_results();
		test_random(300);
		test_backpressure();
		test_streaming();
		test_random(300);
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/hsc_pkg.sv
rtl/hsc_height_if.sv
rtl/hsc_pixel_if.sv
rtl/hsc_isqdiv.sv
rtl/terrain_hillshade_color_top.sv
bench/hsc_pkg.sv
bench/hsc_ifs.sv
bench/terrain_hillshade_color_top_tb.sv
